@@ rtl/pbmc_pkg.sv @@
// Package with mode codes, soft-light tables and shared arithmetic helpers.
package pbmc_pkg;

   typedef logic [3:0] mode_type;
   typedef logic [16:0] tab17_type [256];

   localparam mode_type MODE_NORMAL     = 4'd0;
   localparam mode_type MODE_MULTIPLY   = 4'd1;
   localparam mode_type MODE_SCREEN     = 4'd2;
   localparam mode_type MODE_OVERLAY    = 4'd3;
   localparam mode_type MODE_DARKEN     = 4'd4;
   localparam mode_type MODE_LIGHTEN    = 4'd5;
   localparam mode_type MODE_DODGE      = 4'd6;
   localparam mode_type MODE_BURN       = 4'd7;
   localparam mode_type MODE_HARDLIGHT  = 4'd8;
   localparam mode_type MODE_SOFTLIGHT  = 4'd9;
   localparam mode_type MODE_DIFFERENCE = 4'd10;
   localparam mode_type MODE_EXCLUSION  = 4'd11;
   localparam mode_type MODE_ADD        = 4'd12;

   localparam logic [0:0] CSR_BLEND_MODE = 1'b0;
   localparam logic [0:0] CSR_OPACITY    = 1'b1;

   localparam logic [16:0] SL_ONE = 17'd65536;
   localparam logic [17:0] DIV255_RECIP = 18'd131587;
   localparam logic [8:0] OPACITY_FULL = 9'd256;

   // Exact floor(n / 255) for n below 132626 by reciprocal multiply.
   function automatic logic [8:0] div255(input logic [16:0] n);
      logic [34:0] p;
      p = 35'(n) * 35'(DIV255_RECIP);
      return p[33:25];
   endfunction

   function automatic tab17_type build_q16();
      tab17_type tab;
      longint v;
      for (int i = 0; i < 256; i++) begin
         v = longint'(i);
         tab[i] = 17'((v * 65536 + 127) / 255);
      end
      return tab;
   endfunction

   // Soft-light curve d(v/255) in Q1.16, rounded half up.
   function automatic tab17_type build_curve();
      tab17_type tab;
      longint n;
      longint num;
      longint target;
      longint q;
      longint c;
      for (int i = 0; i < 256; i++) begin
         n = longint'(i);
         if (i <= 63) begin
            num = 16 * n * n * n + 260100 * n - 3060 * n * n;
            tab[i] = 17'((num * 65536 + 8290687) / 16581375);
         end else begin
            target = n << 32;
            q = 0;
            for (int bit_idx = 16; bit_idx >= 0; bit_idx--) begin
               c = q | (longint'(1) << bit_idx);
               if (255 * c * c <= target) q = c;
            end
            if (4 * target >= 255 * (2 * q + 1) * (2 * q + 1)) q = q + 1;
            tab[i] = 17'(q);
         end
      end
      return tab;
   endfunction

   localparam tab17_type Q16_TABLE = build_q16();
   localparam tab17_type CURVE_TABLE = build_curve();

endpackage

@@ rtl/pixel_blend_mode_compositor_core.sv @@
// Top level of the RGBA8 blend-mode compositor with opacity mix.
// This core blends a top RGBA8 pixel onto a base pixel with one of thirteen
// separable blend modes, selected by the blend_mode register, and then mixes
// the blended pixel back toward the base by the opacity register (256ths,
// values above 256 act as 256). Alpha keeps the base value except in normal
// mode, where the top pixel passes whole. Each pixel is one transaction; one
// pixel is accepted every clock unless the output is stalled, and its result
// is built in the five-register pipeline: operand products and table reads,
// division by 255 with the upper half of the dodge and burn quotient, the
// lower quotient half with the second soft-light product, the final per-mode
// selection, and the opacity mix in the output register. The whole pipeline
// holds when the output transaction is stalled, so nothing is lost or
// repeated. Configuration is written through the csr port (index 0
// blend_mode, index 1 opacity) and must only change while no pixels are in
// flight.
module pixel_blend_mode_compositor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // base_red, base_green, base_blue, base_alpha, top_red, top_green, top_blue, top_alpha
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);

   pbmc_pkg::mode_type mode_ff;
   logic [8:0] opacity_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= pbmc_pkg::MODE_NORMAL;
         opacity_ff <= pbmc_pkg::OPACITY_FULL;
      end else if (csr_valid) begin
         case (csr_index)
            pbmc_pkg::CSR_BLEND_MODE: mode_ff <= csr_data[3:0];
            pbmc_pkg::CSR_OPACITY:    opacity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The pipeline advances whenever the output register is empty or being drained.
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic normal;
   always_comb begin
      case (mode_ff) inside
         pbmc_pkg::MODE_NORMAL, [4'd13:4'd15]: normal = 1'b1;
         default: normal = 1'b0;
      endcase
   end

   logic [3:0] vld_ff;
   logic [3:0] vld_in;
   assign vld_in = {vld_ff[2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_tvalid <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         rsp_tvalid <= vld_ff[3];
      end
   end

   // Alpha only needs delaying to line up with the color channels.
   logic [7:0] alpha_ff [4];
   logic [7:0] base_alpha_ff [4];
   logic [7:0] alpha_in;
   assign alpha_in = normal ? req_tdata[63:56] : req_tdata[31:24];

   always_ff @(posedge clock) begin
      if (en) begin
         alpha_ff[0]      <= alpha_in;
         base_alpha_ff[0] <= req_tdata[31:24];
         for (int i = 1; i < 4; i++) begin
            alpha_ff[i]      <= alpha_ff[i - 1];
            base_alpha_ff[i] <= base_alpha_ff[i - 1];
         end
      end
   end

   logic [7:0] blend_x [4];
   logic [7:0] blend_b [4];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      pbmc_channel u_chan (
         .clock (clock),
         .en    (en),
         .mode  (mode_ff),
         .b_in  (req_tdata[8*c +: 8]),
         .t_in  (req_tdata[32 + 8*c +: 8]),
         .x_out (blend_x[c]),
         .b_out (blend_b[c])
      );
   end

   assign blend_x[3] = alpha_ff[3];
   assign blend_b[3] = base_alpha_ff[3];

   // Opacity mix: floor((b*(256-op) + x*op) / 256) on all four channels.
   logic [8:0] op_sat, op_inv;
   logic [31:0] rsp_tdata_in;
   logic [16:0] mix_sum [4];

   always_comb begin
      op_sat = opacity_ff > pbmc_pkg::OPACITY_FULL ? pbmc_pkg::OPACITY_FULL : opacity_ff;
      op_inv = pbmc_pkg::OPACITY_FULL - op_sat;
      for (int c = 0; c < 4; c++) begin
         mix_sum[c] = 17'(blend_b[c]) * 17'(op_inv) + 17'(blend_x[c]) * 17'(op_sat);
         rsp_tdata_in[8*c +: 8] = mix_sum[c][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_tdata <= rsp_tdata_in;
   end

endmodule

@@ rtl/pbmc_channel.sv @@
// One color channel of the blend: four register stages from inputs to blended value.
module pbmc_channel (
   input  logic                 clock,
   input  logic                 en,
   input  pbmc_pkg::mode_type   mode,
   input  logic [7:0]           b_in,
   input  logic [7:0]           t_in,
   output logic [7:0]           x_out,
   output logic [7:0]           b_out
);

   // Stage 1: products, divider operands and table lookups.
   pbmc_pkg::mode_type s1_mode_ff;
   logic [7:0]  s1_b_ff, s1_t_ff;
   logic [15:0] s1_bt_ff, s1_iv_ff, s1_num_ff;
   logic [7:0]  s1_den_ff;
   logic [16:0] s1_bq_ff, s1_lq_ff, s1_cv_ff;
   logic [15:0] s1_num_in;
   logic [7:0]  s1_den_in;

   always_comb begin
      if (mode == pbmc_pkg::MODE_BURN) begin
         s1_num_in = 16'(8'd255 - b_in) * 16'd255;
         s1_den_in = t_in;
      end else begin
         s1_num_in = 16'(b_in) * 16'd255;
         s1_den_in = 8'd255 - t_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mode_ff <= mode;
         s1_b_ff    <= b_in;
         s1_t_ff    <= t_in;
         s1_bt_ff   <= 16'(b_in) * 16'(t_in);
         s1_iv_ff   <= 16'(8'd255 - b_in) * 16'(8'd255 - t_in);
         s1_num_ff  <= s1_num_in;
         s1_den_ff  <= s1_den_in;
         s1_bq_ff   <= pbmc_pkg::Q16_TABLE[b_in];
         s1_lq_ff   <= pbmc_pkg::Q16_TABLE[t_in];
         s1_cv_ff   <= pbmc_pkg::CURVE_TABLE[b_in];
      end
   end

   // Stage 2: divide-by-255 results, upper quotient bits, first soft-light product.
   pbmc_pkg::mode_type s2_mode_ff;
   logic [7:0]  s2_b_ff, s2_t_ff, s2_mul_ff, s2_scr_ff;
   logic [8:0]  s2_bt2_ff, s2_iv2_ff;
   logic [15:0] s2_rem_ff;
   logic [7:0]  s2_den_ff;
   logic [3:0]  s2_qhi_ff;
   logic        s2_sat_ff, s2_low_ff;
   logic [16:0] s2_bq_ff, s2_k_ff, s2_x_ff;
   logic [15:0] s2_rem_in;
   logic [3:0]  s2_qhi_in;
   logic [16:0] s2_k_in, s2_x_in;
   logic [33:0] s2_p;
   logic [8:0]  s2_mul_in, s2_scr_in;

   always_comb begin
      s2_rem_in = s1_num_ff;
      for (int i = 7; i >= 4; i--) begin
         if (s2_rem_in >= (16'(s1_den_ff) << i)) begin
            s2_rem_in = s2_rem_in - (16'(s1_den_ff) << i);
            s2_qhi_in[i - 4] = 1'b1;
         end else begin
            s2_qhi_in[i - 4] = 1'b0;
         end
      end
      s2_p = 34'(s1_bq_ff) * 34'(pbmc_pkg::SL_ONE - s1_bq_ff);
      if (s1_t_ff <= 8'd127) begin
         s2_x_in = s2_p[32:16];
         s2_k_in = 17'(18'(pbmc_pkg::SL_ONE) - (18'(s1_lq_ff) << 1));
      end else begin
         s2_x_in = s1_cv_ff - s1_bq_ff;
         s2_k_in = 17'((18'(s1_lq_ff) << 1) - 18'(pbmc_pkg::SL_ONE));
      end
      s2_mul_in = pbmc_pkg::div255({1'b0, s1_bt_ff});
      s2_scr_in = pbmc_pkg::div255({1'b0, s1_iv_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mode_ff <= s1_mode_ff;
         s2_b_ff    <= s1_b_ff;
         s2_t_ff    <= s1_t_ff;
         s2_mul_ff  <= s2_mul_in[7:0];
         s2_scr_ff  <= 8'd255 - s2_scr_in[7:0];
         s2_bt2_ff  <= pbmc_pkg::div255({s1_bt_ff, 1'b0});
         s2_iv2_ff  <= pbmc_pkg::div255({s1_iv_ff, 1'b0});
         s2_rem_ff  <= s2_rem_in;
         s2_den_ff  <= s1_den_ff;
         s2_qhi_ff  <= s2_qhi_in;
         s2_sat_ff  <= 24'(s1_num_ff) >= (24'(s1_den_ff) << 8);
         s2_low_ff  <= s1_t_ff <= 8'd127;
         s2_bq_ff   <= s1_bq_ff;
         s2_k_ff    <= s2_k_in;
         s2_x_ff    <= s2_x_in;
      end
   end

   // Stage 3: lower quotient bits, simple modes, second soft-light product.
   pbmc_pkg::mode_type s3_mode_ff;
   logic [7:0]  s3_b_ff, s3_t_ff, s3_simple_ff, s3_q_ff;
   logic        s3_sat_ff;
   logic [16:0] s3_r_ff;
   logic [15:0] s3_rem;
   logic [3:0]  s3_qlo;
   logic [33:0] s3_p;
   logic [16:0] s3_r_in;
   logic [7:0]  s3_simple_in;
   logic [8:0]  s3_sum;

   always_comb begin
      s3_rem = s2_rem_ff;
      for (int i = 3; i >= 0; i--) begin
         if (s3_rem >= (16'(s2_den_ff) << i)) begin
            s3_rem = s3_rem - (16'(s2_den_ff) << i);
            s3_qlo[i] = 1'b1;
         end else begin
            s3_qlo[i] = 1'b0;
         end
      end
      s3_p = 34'(s2_k_ff) * 34'(s2_x_ff);
      if (s2_low_ff) s3_r_in = s2_bq_ff - s3_p[32:16];
      else s3_r_in = s2_bq_ff + s3_p[32:16];
      s3_sum = 9'(s2_b_ff) + 9'(s2_t_ff);
      case (s2_mode_ff)
         pbmc_pkg::MODE_MULTIPLY: s3_simple_in = s2_mul_ff;
         pbmc_pkg::MODE_SCREEN:   s3_simple_in = s2_scr_ff;
         pbmc_pkg::MODE_OVERLAY:
            s3_simple_in = s2_b_ff < 8'd128 ? s2_bt2_ff[7:0] : 8'd255 - s2_iv2_ff[7:0];
         pbmc_pkg::MODE_HARDLIGHT:
            s3_simple_in = s2_t_ff < 8'd128 ? s2_bt2_ff[7:0] : 8'd255 - s2_iv2_ff[7:0];
         pbmc_pkg::MODE_DARKEN:   s3_simple_in = s2_b_ff < s2_t_ff ? s2_b_ff : s2_t_ff;
         pbmc_pkg::MODE_LIGHTEN:  s3_simple_in = s2_b_ff > s2_t_ff ? s2_b_ff : s2_t_ff;
         pbmc_pkg::MODE_DIFFERENCE:
            s3_simple_in = s2_b_ff > s2_t_ff ? s2_b_ff - s2_t_ff : s2_t_ff - s2_b_ff;
         pbmc_pkg::MODE_EXCLUSION: s3_simple_in = 8'(s3_sum - s2_bt2_ff);
         pbmc_pkg::MODE_ADD:      s3_simple_in = s3_sum[8] ? 8'd255 : s3_sum[7:0];
         default:                 s3_simple_in = s2_t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_mode_ff   <= s2_mode_ff;
         s3_b_ff      <= s2_b_ff;
         s3_t_ff      <= s2_t_ff;
         s3_simple_ff <= s3_simple_in;
         s3_q_ff      <= {s2_qhi_ff, s3_qlo};
         s3_sat_ff    <= s2_sat_ff;
         s3_r_ff      <= s3_r_in;
      end
   end

   // Stage 4: final selection, soft-light scaling back to 8 bits.
   logic [7:0]  s4_x_ff, s4_b_ff, s4_x_in;
   logic [24:0] s4_scaled;

   always_comb begin
      s4_scaled = (25'(s3_r_ff) << 8) - 25'(s3_r_ff);
      case (s3_mode_ff)
         pbmc_pkg::MODE_DODGE:
            s4_x_in = (s3_t_ff == 8'd255 || s3_sat_ff) ? 8'd255 : s3_q_ff;
         pbmc_pkg::MODE_BURN:
            s4_x_in = (s3_t_ff == 8'd0 || s3_sat_ff) ? 8'd0 : 8'd255 - s3_q_ff;
         pbmc_pkg::MODE_SOFTLIGHT: s4_x_in = s4_scaled[23:16];
         default:                  s4_x_in = s3_simple_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_x_ff <= s4_x_in;
         s4_b_ff <= s3_b_ff;
      end
   end

   assign x_out = s4_x_ff;
   assign b_out = s4_b_ff;

endmodule

@@ rtl/pbmc_checker.sv @@
// Port-level checker for the compositor core and its bind.
module pbmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The input side is ready exactly when the output register can advance.
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Configuration writes are never refused.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind pixel_blend_mode_compositor_core pbmc_checker u_pbmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
